// ===== rtl/core/bfe_pkg.sv =====
// shared types, constants and sizes of the bitstream field extractor
`default_nettype none
package bfe_pkg;

	// sizes of the byte store and of one field
	localparam int MAX_BYTES      = 256;
	localparam int MAX_FIELD_BITS = 32;

	// derived widths
	localparam int BYTE_AW   = $clog2(MAX_BYTES);
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);
	localparam int POS_W     = CNT_W + 3;
	localparam int LEN_W     = $clog2(MAX_FIELD_BITS + 1);
	localparam int WIN_BYTES = (MAX_FIELD_BITS + 7) / 8 + 1;
	localparam int WIN_W     = WIN_BYTES * 8;
	localparam int NB_W      = $clog2(WIN_BYTES + 1);

	// depth of the queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// command codes on the request channel
	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_EXTRACT = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// request payload
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic [5:0] field_length;
	} bfe_in_t;

	// result payload
	typedef struct packed {
		logic [31:0] field_value;
		logic        short_read;
		logic        overflowed;
	} bfe_out_t;

	// classified operation passed from front to back
	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_RESTART = 2'd2
	} bfe_op_kind_t;

	typedef struct packed {
		bfe_op_kind_t     kind;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] req_len;
	} bfe_op_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} bfe_q_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/bfe_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module bfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/bfe_front.sv =====
// front end: accepts requests, classifies them and saturates the field length
`default_nettype none
module bfe_front (
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire bfe_pkg::bfe_in_t       in_data,
	input  wire bfe_pkg::bfe_q_status_t q_status,
	output logic                        q_wr_en,
	output bfe_pkg::bfe_op_t            q_wr_data
);
	import bfe_pkg::*;

	logic             fire;
	logic             keep;
	logic [LEN_W-1:0] req_sat;

	// a request is taken whenever the queue has room
	assign in_ready = !q_status.full;
	assign fire     = in_valid && in_ready;

	// clamp the requested length to the widest field
	always_comb begin
		if ({1'b0, in_data.field_length} > 7'(MAX_FIELD_BITS)) begin
			req_sat = LEN_W'(MAX_FIELD_BITS);
		end else begin
			req_sat = LEN_W'(in_data.field_length);
		end
	end

	// decode the command; the unused code is taken and dropped
	always_comb begin
		keep                = 1'b1;
		q_wr_data.kind      = OP_PUSH;
		q_wr_data.data_byte = in_data.data_byte;
		q_wr_data.req_len   = req_sat;
		case (in_data.cmd)
			CMD_PUSH:    q_wr_data.kind = OP_PUSH;
			CMD_EXTRACT: q_wr_data.kind = OP_EXTRACT;
			CMD_RESTART: q_wr_data.kind = OP_RESTART;
			default:     keep = 1'b0;
		endcase
	end

	assign q_wr_en = fire && keep;

endmodule
`default_nettype wire

// ===== rtl/core/bfe_queue.sv =====
// short operation queue between front and back
`default_nettype none
module bfe_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr_en,
	input  wire bfe_pkg::bfe_op_t       wr_data,
	input  wire logic                   rd_en,
	output bfe_pkg::bfe_op_t            rd_data,
	output bfe_pkg::bfe_q_status_t      status
);
	import bfe_pkg::*;

	bfe_op_t           entry_q [QDEPTH];
	logic [QAW-1:0]    wr_ptr_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign status.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_wr        = wr_en && !status.full;
	assign do_rd        = rd_en && !status.empty;
	assign rd_data      = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/bfe_back.sv =====
// back end: message counters, byte store access and field assembly
`default_nettype none
module bfe_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire bfe_pkg::bfe_op_t       op,
	input  wire bfe_pkg::bfe_q_status_t q_status,
	output logic                        q_rd_en,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output bfe_pkg::bfe_out_t           out_data
);
	import bfe_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_DONE = 3'b100
	} bfe_state_t;

	bfe_state_t        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [POS_W-1:0]  pos_q;
	logic              ovf_q;

	// per-extract registers
	logic [CNT_W-1:0]  idx_q;
	logic [NB_W-1:0]   nbytes_q;
	logic [NB_W-1:0]   rd_cnt_q;
	logic              rd_pend_q;
	logic [LEN_W-1:0]  take_q;
	logic [2:0]        sh_q;
	logic              short_q;
	logic              ovf_snap_q;
	logic [WIN_W-1:0]  win_q;

	// result register
	logic              res_valid_q;
	bfe_out_t          res_q;

	logic              pop;
	logic [POS_W-1:0]  total;
	logic [POS_W-1:0]  remain;
	logic [LEN_W-1:0]  take;
	logic [LEN_W:0]    span;
	logic [LEN_W+1:0]  nb_wide;
	logic              ram_we;
	logic              ram_re;
	logic [BYTE_AW-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic [WIN_W-1:0]  shifted;
	logic [WIN_W-1:0]  mask;

	// an extract waits until the result slot is free
	assign pop = (state_q == ST_IDLE) && !q_status.empty
		&& ((op.kind != OP_EXTRACT) || !res_valid_q);
	assign q_rd_en = pop;

	// bits left and bits taken for the current extract
	assign total   = {count_q, 3'b000};
	assign remain  = (pos_q < total) ? (total - pos_q) : '0;
	assign take    = (POS_W'(op.req_len) < remain) ? op.req_len : LEN_W'(remain);
	assign span    = (LEN_W + 1)'(pos_q[2:0]) + (LEN_W + 1)'(take);
	assign nb_wide = ((LEN_W + 2)'(span) + (LEN_W + 2)'(7)) >> 3;

	// byte store
	assign ram_we    = pop && (op.kind == OP_PUSH) && (count_q < CNT_W'(MAX_BYTES));
	assign ram_re    = (state_q == ST_READ) && (rd_cnt_q < nbytes_q);
	assign ram_raddr = BYTE_AW'(idx_q + CNT_W'(rd_cnt_q));

	bfe_ram #(
		.WIDTH (8),
		.DEPTH (MAX_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[BYTE_AW-1:0]),
		.wdata (op.data_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// align the window and keep only the taken bits
	assign shifted = win_q >> sh_q;
	assign mask    = (WIN_W'(1) << take_q) - WIN_W'(1);

	// sequencer and message counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			ovf_q       <= 1'b0;
			rd_cnt_q    <= '0;
			rd_pend_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && out_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (op.kind)
							OP_PUSH: begin
								if (count_q < CNT_W'(MAX_BYTES)) begin
									count_q <= count_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_RESTART: begin
								count_q <= '0;
								pos_q   <= '0;
								ovf_q   <= 1'b0;
							end
							OP_EXTRACT: begin
								pos_q    <= pos_q + POS_W'(take);
								rd_cnt_q <= '0;
								state_q  <= ST_READ;
							end
							default: begin
								count_q <= count_q;
							end
						endcase
					end
				end
				ST_READ: begin
					rd_pend_q <= ram_re;
					if (ram_re) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (!ram_re && !rd_pend_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// extract parameters and byte window
	always_ff @(posedge clk) begin
		if (pop && (op.kind == OP_EXTRACT)) begin
			idx_q      <= CNT_W'(pos_q >> 3);
			nbytes_q   <= NB_W'(nb_wide);
			take_q     <= take;
			sh_q       <= 3'(3'd0 - span[2:0]);
			short_q    <= (take < op.req_len);
			ovf_snap_q <= ovf_q;
			win_q      <= '0;
		end else if (rd_pend_q) begin
			win_q <= {win_q[WIN_W-9:0], ram_rdata};
		end
		if (state_q == ST_DONE) begin
			res_q.field_value <= 32'(shifted & mask);
			res_q.short_read  <= short_q;
			res_q.overflowed  <= ovf_snap_q;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/bitstream_field_extractor.sv =====
// top level of the msb-first bitstream field extractor
`default_nettype none
// Push requests append bytes to a message store, restart requests begin a new
// message, and extract requests return the next field_length bits (at most
// MAX_FIELD_BITS) most significant bit first, with short_read set when fewer
// bits were left and overflowed set once a byte was dropped for lack of room.
// Requests are taken whenever the two-entry operation queue has room, also
// while a result waits on the output. The back end runs one queued operation
// at a time: a push or restart is done as it is popped, while an extract reads
// the stored bytes the field spans, up to five, through the single read port
// of the byte store, which gives one byte a cycle, then registers the result.
// Store entries are undefined after reset; no clearing pass is run.
module bitstream_field_extractor (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire bfe_pkg::bfe_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output bfe_pkg::bfe_out_t      out_data
);
	import bfe_pkg::*;

	bfe_op_t       q_wr_data;
	bfe_op_t       q_rd_data;
	bfe_q_status_t q_status;
	logic          q_wr_en;
	logic          q_rd_en;

	// request classification
	bfe_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_status  (q_status),
		.q_wr_en   (q_wr_en),
		.q_wr_data (q_wr_data)
	);

	// decoupling queue
	bfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr_en),
		.wr_data (q_wr_data),
		.rd_en   (q_rd_en),
		.rd_data (q_rd_data),
		.status  (q_status)
	);

	// execution
	bfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (q_rd_data),
		.q_status  (q_status),
		.q_rd_en   (q_rd_en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== test/bitstream_field_extractor_tb.sv =====
// self-checking testbench of the msb-first bitstream field extractor
module bitstream_field_extractor_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bfe_pkg::*;

	// the two-bit command space has one code the block ignores
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	bfe_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	bfe_out_t out_data;

	// idle percentages of sender and receiver, set per phase
	int unsigned send_idle = 15;
	int unsigned recv_idle = 49;
	int          errors    = 0;

	bfe_in_t  pending_requests[$];
	bfe_out_t expected_fields[$];

	// own copy of the message store and read pointer
	logic [7:0]       msg_bytes [MAX_BYTES];
	logic [CNT_W-1:0] msg_len    = '0;
	logic [POS_W-1:0] read_pos   = '0;
	logic             ovf_sticky = 1'b0;

	bitstream_field_extractor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #1 clk = ~clk;

	// update the message copy and work out the field an extract returns
	task automatic apply_request(input bfe_in_t r);
		int          req;
		int          total;
		int          remain;
		int          take;
		int          pos;
		logic [31:0] acc;
		bfe_out_t    res;
		case (r.cmd)
			CMD_PUSH: begin
				if (msg_len < MAX_BYTES) begin
					msg_bytes[msg_len[BYTE_AW-1:0]] = r.data_byte;
					msg_len = msg_len + 1'b1;
				end else begin
					ovf_sticky = 1'b1;
				end
			end
			CMD_RESTART: begin
				msg_len    = '0;
				read_pos   = '0;
				ovf_sticky = 1'b0;
			end
			CMD_EXTRACT: begin
				req    = (r.field_length > MAX_FIELD_BITS) ? MAX_FIELD_BITS
				                                           : int'(r.field_length);
				total  = int'(msg_len) * 8;
				remain = (int'(read_pos) < total) ? total - int'(read_pos) : 0;
				take   = (req < remain) ? req : remain;
				acc    = '0;
				for (int i = 0; i < take; i++) begin
					pos = int'(read_pos) + i;
					acc = {acc[30:0], msg_bytes[BYTE_AW'(pos >> 3)][3'(7 - (pos % 8))]};
				end
				read_pos            = read_pos + take[POS_W-1:0];
				res.field_value     = acc;
				res.short_read      = (take < req);
				res.overflowed      = ovf_sticky;
				expected_fields.push_back(res);
			end
			default: ;
		endcase
	endtask

	// request driver: holds each request until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready)
				apply_request(in_data);
			if (!in_valid || in_ready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle) begin
					in_valid <= 1'b1;
					in_data  <= pending_requests.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compares each accepted result with the oldest expected field
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_fields.size() == 0) begin
					$error("unexpected result: field_value %h", out_data.field_value);
					errors++;
				end else begin
					bfe_out_t exp_res;
					exp_res = expected_fields.pop_front();
					if (out_data.field_value !== exp_res.field_value) begin
						$error("field_value: expected %h, got %h",
						       exp_res.field_value, out_data.field_value);
						errors++;
					end
					if (out_data.short_read !== exp_res.short_read) begin
						$error("short_read: expected %b, got %b",
						       exp_res.short_read, out_data.short_read);
						errors++;
					end
					if (out_data.overflowed !== exp_res.overflowed) begin
						$error("overflowed: expected %b, got %b",
						       exp_res.overflowed, out_data.overflowed);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic bfe_in_t make_req(logic [1:0] cmd, logic [7:0] b, logic [5:0] len);
		bfe_in_t r;
		r.cmd          = cmd;
		r.data_byte    = b;
		r.field_length = len;
		return r;
	endfunction

	// mostly ordinary lengths, some zero, some above the field limit
	function automatic logic [5:0] pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return 6'd0;
		else if (r < 90)
			return 6'($urandom_range(1, 32));
		else
			return 6'($urandom_range(33, 63));
	endfunction

	// one message: an optional restart, bytes with extracts and unused codes in between, then a few extracts past the end
	task automatic queue_message(input int n_bytes, input int push_pct, input bit restart);
		int          pushed;
		int unsigned roll;
		pushed = 0;
		if (restart)
			pending_requests.push_back(make_req(CMD_RESTART, 8'($urandom), 6'($urandom)));
		while (pushed < n_bytes) begin
			roll = $urandom_range(99);
			if (roll < push_pct) begin
				pending_requests.push_back(make_req(CMD_PUSH, 8'($urandom), 6'($urandom)));
				pushed++;
			end else if (roll < 96) begin
				pending_requests.push_back(make_req(CMD_EXTRACT, 8'($urandom), pick_length()));
			end else begin
				pending_requests.push_back(make_req(CMD_UNUSED, 8'($urandom), 6'($urandom)));
			end
		end
		repeat ($urandom_range(1, 6))
			pending_requests.push_back(make_req(CMD_EXTRACT, 8'($urandom), pick_length()));
	endtask

	// one long message that can run past the store, then short ones up to the budget
	task automatic fill_phase(input int budget);
		queue_message($urandom_range(252, 264), 85, 1'b1);
		while (pending_requests.size() < budget)
			queue_message($urandom_range(1, 24), 55, ($urandom_range(4) != 0));
	endtask

	task automatic drain_phase();
		while (pending_requests.size() != 0 || in_valid || expected_fields.size() != 0)
			@(posedge clk);
	endtask

	// stimulus and end of run
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: empty message, byte extremes, length extremes, ignored code
		pending_requests.push_back(make_req(CMD_EXTRACT, 8'h00, 6'd8));
		pending_requests.push_back(make_req(CMD_EXTRACT, 8'hFF, 6'd0));
		pending_requests.push_back(make_req(CMD_PUSH,    8'h00, 6'd0));
		pending_requests.push_back(make_req(CMD_PUSH,    8'hFF, 6'd63));
		pending_requests.push_back(make_req(CMD_PUSH,    8'h80, 6'd0));
		pending_requests.push_back(make_req(CMD_PUSH,    8'h7F, 6'd0));
		pending_requests.push_back(make_req(CMD_PUSH,    8'hA5, 6'd0));
		pending_requests.push_back(make_req(CMD_EXTRACT, 8'h00, 6'd0));
		pending_requests.push_back(make_req(CMD_EXTRACT, 8'h00, 6'd1));
		pending_requests.push_back(make_req(CMD_EXTRACT, 8'h00, 6'd32));
		pending_requests.push_back(make_req(CMD_EXTRACT, 8'h00, 6'd63));
		pending_requests.push_back(make_req(CMD_UNUSED,  8'hFF, 6'd63));
		pending_requests.push_back(make_req(CMD_PUSH,    8'h5A, 6'd0));
		pending_requests.push_back(make_req(CMD_EXTRACT, 8'h00, 6'd8));
		pending_requests.push_back(make_req(CMD_EXTRACT, 8'h00, 6'd40));
		pending_requests.push_back(make_req(CMD_RESTART, 8'hFF, 6'd63));
		pending_requests.push_back(make_req(CMD_PUSH,    8'hC3, 6'd0));
		pending_requests.push_back(make_req(CMD_PUSH,    8'h3C, 6'd0));
		pending_requests.push_back(make_req(CMD_PUSH,    8'hFF, 6'd0));
		pending_requests.push_back(make_req(CMD_PUSH,    8'h01, 6'd0));
		pending_requests.push_back(make_req(CMD_EXTRACT, 8'h00, 6'd32));
		pending_requests.push_back(make_req(CMD_EXTRACT, 8'h00, 6'd0));
		pending_requests.push_back(make_req(CMD_EXTRACT, 8'h00, 6'd1));
		drain_phase();

		// sender idles lightly, receiver heavily
		fill_phase(480);
		drain_phase();

		// the other way round
		send_idle = 49;
		recv_idle = 15;
		fill_phase(480);
		drain_phase();

		// no idling on either side
		send_idle = 0;
		recv_idle = 0;
		fill_phase(480);
		drain_phase();

		// let any stray result show up
		repeat (24) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== bitstream_field_extractor.f =====
rtl/core/bfe_pkg.sv
rtl/core/bfe_ram.sv
rtl/core/bfe_front.sv
rtl/core/bfe_queue.sv
rtl/core/bfe_back.sv
rtl/core/bitstream_field_extractor.sv
test/bitstream_field_extractor_tb.sv
